### rtl/rhsv_pkg.sv
// ----------------------------------------------------------------------------
// rhsv_pkg: shared types and constants for the RGB to HSV converter
// Channel and result widths, pipeline depths and the inter-module structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rhsv_pkg;

  localparam int CHAN_W = 8;
  localparam int HUE_W  = 9;
  localparam int SAT_W  = 17;
  localparam int NUM_W  = 17;

  // Hue sector offsets in degrees.
  localparam logic [HUE_W-1:0] DEG_GREEN = 9'd120;
  localparam logic [HUE_W-1:0] DEG_BLUE  = 9'd240;
  localparam logic [HUE_W-1:0] DEG_FULL  = 9'd360;

  // Front end stages and long division stages.
  localparam int PREP_STAGES   = 4;
  localparam int DIV_STEPS     = SAT_W;
  localparam int DIV_PER_STAGE = 3;
  localparam int DIV_STAGES    = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
  localparam int PIPE_STAGES   = PREP_STAGES + DIV_STAGES;

  typedef struct packed {
    logic [PIPE_STAGES-1:0] en;
    logic                   out_valid;
    logic                   in_stall;
  } pipe_ctrl_t;

  typedef struct packed {
    logic [CHAN_W-1:0] hi;
    logic [CHAN_W-1:0] spread;
    logic [NUM_W-1:0]  num;
  } prep_out_t;

endpackage

### rtl/rhsv_ctrl.sv
// ----------------------------------------------------------------------------
// rhsv_ctrl: pipeline valid tracking and flow control
// Carries one valid bit per stage and lets each stage load when it is empty
// or when the stage after it moves, so bubbles close up under a stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rhsv_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pixel_valid,
  input  logic                 hsv_stall,
  output rhsv_pkg::pipe_ctrl_t ctrl
);

  localparam int N = rhsv_pkg::PIPE_STAGES;

  logic [N-1:0] valid;
  logic [N-1:0] valid_next;
  logic [N:0]   ready;

  always_comb begin
    ready[N] = !hsv_stall;
    for (int i = N - 1; i >= 0; i--) begin
      ready[i] = !valid[i] || ready[i+1];
    end
  end

  assign valid_next = {valid[N-2:0], pixel_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int i = 0; i < N; i++) begin
        if (ready[i]) begin
          valid[i] <= valid_next[i];
        end
      end
    end
  end

  assign ctrl.en        = ready[N-1:0];
  assign ctrl.out_valid = valid[N-1];
  assign ctrl.in_stall  = !ready[0];

endmodule

### rtl/rhsv_prep.sv
// ----------------------------------------------------------------------------
// rhsv_prep: front end of the converter
// Finds the largest and smallest channel and the hue sector, then forms the
// spread and the hue numerator that the dividers consume.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rhsv_prep (
  input  logic                                clk,
  input  logic [rhsv_pkg::PREP_STAGES-1:0]    en,
  input  logic [rhsv_pkg::CHAN_W-1:0]         red,
  input  logic [rhsv_pkg::CHAN_W-1:0]         green,
  input  logic [rhsv_pkg::CHAN_W-1:0]         blue,
  output rhsv_pkg::prep_out_t                 prep
);

  localparam int CW = rhsv_pkg::CHAN_W;
  localparam int NW = rhsv_pkg::NUM_W;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  // Stage 0: input capture.
  logic [CW-1:0] r0, g0, b0;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r0 <= red;
      g0 <= green;
      b0 <= blue;
    end
  end

  // Stage 1: sector, extremes and the signed channel difference.
  sector_t       sec_c, sec1;
  logic [CW-1:0] hi_c, lo_c, hi1, lo1;
  logic [CW:0]   d_c, d1;

  always_comb begin
    if (r0 >= g0 && r0 >= b0) begin
      sec_c = SEC_RED;
      hi_c  = r0;
      d_c   = {1'b0, g0} - {1'b0, b0};
    end else if (g0 >= b0) begin
      sec_c = SEC_GREEN;
      hi_c  = g0;
      d_c   = {1'b0, b0} - {1'b0, r0};
    end else begin
      sec_c = SEC_BLUE;
      hi_c  = b0;
      d_c   = {1'b0, r0} - {1'b0, g0};
    end
    lo_c = (r0 < g0) ? r0 : g0;
    if (b0 < lo_c) begin
      lo_c = b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sec1 <= sec_c;
      hi1  <= hi_c;
      lo1  <= lo_c;
      d1   <= d_c;
    end
  end

  // Stage 2: spread.
  sector_t       sec2;
  logic [CW-1:0] hi2, spread2;
  logic [CW:0]   d2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sec2    <= sec1;
      hi2     <= hi1;
      spread2 <= hi1 - lo1;
      d2      <= d1;
    end
  end

  // Stage 3: numerator = 60 * difference + sector offset * spread. A negative
  // difference in the red sector wraps by a full turn.
  logic [rhsv_pkg::HUE_W-1:0] offset;
  logic [NW-1:0]              off_prod;
  logic signed [NW:0]         d_ext, sixty_d, num_s;

  always_comb begin
    case (sec2)
      SEC_RED:   offset = d2[CW] ? rhsv_pkg::DEG_FULL : '0;
      SEC_GREEN: offset = rhsv_pkg::DEG_GREEN;
      SEC_BLUE:  offset = rhsv_pkg::DEG_BLUE;
      default:   offset = '0;
    endcase
    off_prod = NW'(offset) * NW'(spread2);
    d_ext    = $signed({{(NW - CW){d2[CW]}}, d2});
    sixty_d  = (d_ext <<< 6) - (d_ext <<< 2);
    num_s    = $signed({1'b0, off_prod}) + sixty_d;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      prep.hi     <= hi2;
      prep.spread <= spread2;
      prep.num    <= num_s[NW-1:0];
    end
  end

endmodule

### rtl/rhsv_div.sv
// ----------------------------------------------------------------------------
// rhsv_div: pipelined restoring divider
// Divides an 8-bit initial remainder followed by 17 dividend bits by an
// 8-bit divisor, a few quotient bits per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rhsv_div (
  input  logic                               clk,
  input  logic [rhsv_pkg::DIV_STAGES-1:0]    en,
  input  logic [rhsv_pkg::CHAN_W-1:0]        divisor,
  input  logic [rhsv_pkg::CHAN_W-1:0]        rem_init,
  input  logic [rhsv_pkg::SAT_W-1:0]         dividend,
  output logic [rhsv_pkg::SAT_W-1:0]         quotient
);

  localparam int CW  = rhsv_pkg::CHAN_W;
  localparam int QW  = rhsv_pkg::SAT_W;
  localparam int NS  = rhsv_pkg::DIV_STAGES;
  localparam int PER = rhsv_pkg::DIV_PER_STAGE;

  // The work word shifts dividend bits out at the top and quotient bits in
  // at the bottom; after all steps it holds the quotient.
  typedef struct packed {
    logic [CW-1:0] rem;
    logic [QW-1:0] work;
  } div_state_t;

  function automatic div_state_t div_step(div_state_t st, logic [CW-1:0] dv);
    logic [CW:0] trial;
    div_state_t  res;
    trial    = {st.rem, st.work[QW-1]};
    res.work = {st.work[QW-2:0], 1'b0};
    if (trial >= {1'b0, dv}) begin
      res.rem     = CW'(trial - {1'b0, dv});
      res.work[0] = 1'b1;
    end else begin
      res.rem = trial[CW-1:0];
    end
    return res;
  endfunction

  div_state_t    stg_q  [NS];
  logic [CW-1:0] dvsr_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    div_state_t    cur, nxt;
    logic [CW-1:0] dv;

    if (s == 0) begin : g_first
      assign cur.rem  = rem_init;
      assign cur.work = dividend;
      assign dv       = divisor;
    end else begin : g_rest
      assign cur = stg_q[s-1];
      assign dv  = dvsr_q[s-1];
    end

    always_comb begin
      nxt = cur;
      for (int k = 0; k < PER; k++) begin
        if (s * PER + k < rhsv_pkg::DIV_STEPS) begin
          nxt = div_step(nxt, dv);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        stg_q[s]  <= nxt;
        dvsr_q[s] <= dv;
      end
    end
  end

  assign quotient = stg_q[NS-1].work;

endmodule

### rtl/rgb_to_hsv_converter_unit.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_unit: pipelined RGB to HSV pixel converter
// Throughput: one pixel per cycle while hsv_stall is low; the 17-step divider,
//   three quotient bits per stage over six stages, sets the depth.
// Reset: synchronous rst empties the pipeline; no result is pending after it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// The pipeline is ten register stages deep. Four front end stages register
// the pixel, find the largest and smallest channel and the hue sector, form
// the spread, and build the hue numerator 60 * difference + offset * spread.
// Two identical long dividers then run side by side for six stages: one
// divides the hue numerator by the spread, the other divides spread * 65536
// by the largest channel for saturation. A grey pixel (zero spread) forces
// hue to zero, and a black pixel forces saturation to zero; these flags ride
// along with brightness in a small side pipe.
//
// Each stage loads when it is empty or when the stage after it moves, so a
// stall on the result side holds everything in place without losing or
// repeating a request, and empty slots are squeezed out behind it.

module rgb_to_hsv_converter_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pixel_valid,
  output logic                          pixel_stall,
  input  logic [rhsv_pkg::CHAN_W-1:0]   red,
  input  logic [rhsv_pkg::CHAN_W-1:0]   green,
  input  logic [rhsv_pkg::CHAN_W-1:0]   blue,
  output logic                          hsv_valid,
  input  logic                          hsv_stall,
  output logic [rhsv_pkg::HUE_W-1:0]    hue,
  output logic [rhsv_pkg::SAT_W-1:0]    saturation,
  output logic [rhsv_pkg::CHAN_W-1:0]   brightness
);

  localparam int CW = rhsv_pkg::CHAN_W;
  localparam int SW = rhsv_pkg::SAT_W;
  localparam int PS = rhsv_pkg::PREP_STAGES;
  localparam int NS = rhsv_pkg::DIV_STAGES;

  typedef struct packed {
    logic [CW-1:0] hi;
    logic          hue_zero;
    logic          sat_zero;
  } side_t;

  rhsv_pkg::pipe_ctrl_t ctrl;
  rhsv_pkg::prep_out_t  prep;

  rhsv_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .hsv_stall   (hsv_stall),
    .ctrl        (ctrl)
  );

  rhsv_prep u_prep (
    .clk   (clk),
    .en    (ctrl.en[PS-1:0]),
    .red   (red),
    .green (green),
    .blue  (blue),
    .prep  (prep)
  );

  // Hue divider: the numerator is below 512 times the spread, so its top
  // bits start the remainder at zero and all 17 bits are shifted in.
  logic [SW-1:0] hue_q;

  rhsv_div u_hue_div (
    .clk      (clk),
    .en       (ctrl.en[PS+NS-1:PS]),
    .divisor  (prep.spread),
    .rem_init ('0),
    .dividend (prep.num),
    .quotient (hue_q)
  );

  // Saturation divider: spread * 65536 over the largest channel. The top
  // seven dividend bits (spread >> 1) are already below the divisor, so they
  // seed the remainder and the rest yields exactly 17 quotient bits.
  logic [SW-1:0] sat_q;
  logic [SW-1:0] sat_dividend;

  assign sat_dividend = {prep.spread[0], {(SW - 1){1'b0}}};

  rhsv_div u_sat_div (
    .clk      (clk),
    .en       (ctrl.en[PS+NS-1:PS]),
    .divisor  (prep.hi),
    .rem_init (prep.spread >> 1),
    .dividend (sat_dividend),
    .quotient (sat_q)
  );

  // Side pipe that keeps brightness and the special-case flags in step with
  // the dividers.
  side_t side_in;
  side_t side_q [NS];

  assign side_in.hi       = prep.hi;
  assign side_in.hue_zero = (prep.spread == '0);
  assign side_in.sat_zero = (prep.hi == '0);

  always_ff @(posedge clk) begin
    if (ctrl.en[PS]) begin
      side_q[0] <= side_in;
    end
    for (int s = 1; s < NS; s++) begin
      if (ctrl.en[PS+s]) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign pixel_stall = ctrl.in_stall;
  assign hsv_valid   = ctrl.out_valid;
  assign hue         = side_q[NS-1].hue_zero ? '0 : hue_q[rhsv_pkg::HUE_W-1:0];
  assign saturation  = side_q[NS-1].sat_zero ? '0 : sat_q;
  assign brightness  = side_q[NS-1].hi;

`ifndef SYNTHESIS
  // With no result waiting, every stage can move, so the input never stalls.
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !hsv_valid |-> !pixel_stall)
    else $error("pixel request stalled while the result side is empty");

  // A black pixel has neither hue nor saturation.
  a_black_pixel: assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && brightness == '0) |-> (hue == '0 && saturation == '0))
    else $error("black pixel gave nonzero hue or saturation");

  // Results stay within their ranges.
  a_ranges: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> (hue < 9'd360 && saturation <= 17'd65536))
    else $error("hue or saturation out of range");

  // A stalled result must not vanish.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && hsv_stall) |=> hsv_valid)
    else $error("stalled result was dropped");
`endif

endmodule
